// ----- design/complex_dot_product_conj_top_macros.svh -----
// ----------------------------------------------------------------------------
// complex_dot_product_conj_top_macros
// assertion helpers used by the dot product queue
// ----------------------------------------------------------------------------
`ifndef COMPLEX_DOT_PRODUCT_CONJ_TOP_MACROS_SVH
`define COMPLEX_DOT_PRODUCT_CONJ_TOP_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define CDP_ASSERT_NEVER(lbl, cond, msg) \
  `CDP_ASSERT(lbl, !(cond), msg)

`endif

// ----- design/cdp_pkg.sv -----
// ----------------------------------------------------------------------------
// cdp_pkg
// shared types and constants of the complex dot product block
// ----------------------------------------------------------------------------
`default_nettype none

package cdp_pkg;

  // default widths
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACC_BITS_DEF    = 48;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // register port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONJ_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONJ_Y = 1'd1;

  // per beat control tag carried through the queue
  typedef struct packed {
    logic last;
    logic no_element;
  } cdp_tag_t;

endpackage

`default_nettype wire

// ----- design/cdp_queue.sv -----
// ----------------------------------------------------------------------------
// cdp_queue
// short register queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_dot_product_conj_top_macros.svh"

module cdp_queue
  import cdp_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // queue checks
  `CDP_ASSERT_NEVER(a_push_when_full, push && full, "queue push while full")
  `CDP_ASSERT_NEVER(a_pop_when_empty, pop && !not_empty, "queue pop while empty")
  `CDP_ASSERT(a_count_up, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1), "count not raised")
  `CDP_ASSERT(a_count_hold, (!push && !pop) |=> $stable(cnt_r), "count moved while idle")

endmodule

`default_nettype wire

// ----- design/cdp_front.sv -----
// ----------------------------------------------------------------------------
// cdp_front
// register port, input acceptance and operand conjugation
// ----------------------------------------------------------------------------
`default_nettype none

module cdp_front
  import cdp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int IN_DATA_W   = ((4 * SAMPLE_BITS + 7) / 8) * 8,
  parameter int ENTRY_W     = 4 * SAMPLE_BITS + 2 + $bits(cdp_tag_t)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // register port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tuser,
  input  wire logic                  in_tlast,
  // queue write side
  output logic                       q_push,
  output logic      [ENTRY_W-1:0]    q_data,
  input  wire logic                  q_full
);

  localparam int SB = SAMPLE_BITS;

  logic conj_x_r, conj_x_nxt;
  logic conj_y_r, conj_y_nxt;
  logic cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  logic signed [SB-1:0] xr, xi, yr, yi;
  logic signed [SB:0]   xi_c, yi_c;
  cdp_tag_t             tag;

  // register writes
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_comb begin
    conj_x_nxt = conj_x_r;
    conj_y_nxt = conj_y_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_CONJ_X: conj_x_nxt = cfg_pwdata[0];
        REG_CONJ_Y: conj_y_nxt = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conj_x_r <= 1'b0;
      conj_y_r <= 1'b0;
    end else begin
      conj_x_r <= conj_x_nxt;
      conj_y_r <= conj_y_nxt;
    end
  end

  // register reads
  always_comb begin
    case (cfg_idx)
      REG_CONJ_X: cfg_prdata = CFG_DATA_W'(conj_x_r);
      REG_CONJ_Y: cfg_prdata = CFG_DATA_W'(conj_y_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // unpack samples
  assign xr = in_tdata[0*SB +: SB];
  assign xi = in_tdata[1*SB +: SB];
  assign yr = in_tdata[2*SB +: SB];
  assign yi = in_tdata[3*SB +: SB];

  // conjugation, one bit wider so the most negative sample negates exactly
  assign xi_c = conj_x_r ? -((SB+1)'(xi)) : (SB+1)'(xi);
  assign yi_c = conj_y_r ? -((SB+1)'(yi)) : (SB+1)'(yi);

  assign tag.last       = in_tlast;
  assign tag.no_element = in_tuser;

  // queue write
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;
  assign q_data    = {tag, yi_c, yr, xi_c, xr};

endmodule

`default_nettype wire

// ----- design/cdp_back.sv -----
// ----------------------------------------------------------------------------
// cdp_back
// complex multiply, saturating accumulation and result register
// ----------------------------------------------------------------------------
`default_nettype none

module cdp_back
  import cdp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = ACC_BITS_DEF,
  parameter int OUT_DATA_W  = ((2 * ACC_BITS + 7) / 8) * 8,
  parameter int ENTRY_W     = 4 * SAMPLE_BITS + 2 + $bits(cdp_tag_t)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // queue read side
  input  wire logic                  q_not_empty,
  input  wire logic [ENTRY_W-1:0]    q_data,
  output logic                       q_pop,
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,
  output logic                       out_tuser
);

  localparam int SB     = SAMPLE_BITS;
  localparam int OPW    = SB + 1;
  localparam int PROD_W = 2 * OPW;
  localparam int TERM_W = PROD_W + 1;
  localparam int SUM_W  = ((ACC_BITS > TERM_W) ? ACC_BITS : TERM_W) + 1;
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  // queue entry fields
  logic signed [SB-1:0]  ar_q, br_q;
  logic signed [OPW-1:0] ai_q, bi_q, ar_e, br_e;
  cdp_tag_t              tag_q;

  assign ar_q  = q_data[0 +: SB];
  assign ai_q  = q_data[SB +: OPW];
  assign br_q  = q_data[SB + OPW +: SB];
  assign bi_q  = q_data[2*SB + OPW +: OPW];
  assign tag_q = q_data[2*SB + 2*OPW +: $bits(cdp_tag_t)];
  assign ar_e  = OPW'(ar_q);
  assign br_e  = OPW'(br_q);

  // product stage
  logic                     p_v_r, p_v_nxt;
  cdp_tag_t                 p_tag_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;

  // accumulator state
  logic signed [ACC_BITS-1:0] acc_re_r, acc_re_nxt;
  logic signed [ACC_BITS-1:0] acc_im_r, acc_im_nxt;
  logic                       sat_r, sat_nxt;

  // result register
  logic                       out_v_r, out_v_nxt;
  logic signed [ACC_BITS-1:0] res_re_r, res_im_r;
  logic                       res_ovf_r;

  logic adv, fire;
  logic signed [TERM_W-1:0]   term_re, term_im;
  logic signed [SUM_W-1:0]    sum_re, sum_im;
  logic                       fit_re, fit_im;
  logic signed [ACC_BITS-1:0] new_re, new_im;
  logic                       new_sat;

  // whole back part holds only when a last beat meets a full result register
  assign adv   = !(p_v_r && p_tag_r.last && out_v_r && !out_tready);
  assign fire  = p_v_r && adv;
  assign q_pop = q_not_empty && adv;

  always_comb begin
    p_v_nxt = p_v_r;
    if (adv) begin
      p_v_nxt = q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= p_v_nxt;
    end
  end

  // four real products of the complex multiply
  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_tag_r <= tag_q;
      p_rr_r  <= ar_e * br_e;
      p_ii_r  <= ai_q * bi_q;
      p_ri_r  <= ar_e * bi_q;
      p_ir_r  <= ai_q * br_e;
    end
  end

  // exact sums, then one clamp to the accumulator range
  assign term_re = TERM_W'(p_rr_r) - TERM_W'(p_ii_r);
  assign term_im = TERM_W'(p_ri_r) + TERM_W'(p_ir_r);
  assign sum_re  = SUM_W'(acc_re_r) + SUM_W'(term_re);
  assign sum_im  = SUM_W'(acc_im_r) + SUM_W'(term_im);
  assign fit_re  = (&sum_re[SUM_W-1:ACC_BITS-1]) || !(|sum_re[SUM_W-1:ACC_BITS-1]);
  assign fit_im  = (&sum_im[SUM_W-1:ACC_BITS-1]) || !(|sum_im[SUM_W-1:ACC_BITS-1]);

  always_comb begin
    new_re  = acc_re_r;
    new_im  = acc_im_r;
    new_sat = sat_r;
    if (!p_tag_r.no_element) begin
      new_re  = fit_re ? sum_re[ACC_BITS-1:0] : (sum_re[SUM_W-1] ? ACC_MIN : ACC_MAX);
      new_im  = fit_im ? sum_im[ACC_BITS-1:0] : (sum_im[SUM_W-1] ? ACC_MIN : ACC_MAX);
      new_sat = sat_r || !fit_re || !fit_im;
    end
  end

  // accumulator update, cleared after a last beat
  always_comb begin
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    sat_nxt    = sat_r;
    if (fire) begin
      if (p_tag_r.last) begin
        acc_re_nxt = '0;
        acc_im_nxt = '0;
        sat_nxt    = 1'b0;
      end else begin
        acc_re_nxt = new_re;
        acc_im_nxt = new_im;
        sat_nxt    = new_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
      sat_r    <= 1'b0;
    end else begin
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
      sat_r    <= sat_nxt;
    end
  end

  // result register
  always_comb begin
    out_v_nxt = out_v_r;
    if (fire && p_tag_r.last) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && p_tag_r.last) begin
      res_re_r  <= new_re;
      res_im_r  <= new_im;
      res_ovf_r <= new_sat;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'({res_im_r, res_re_r});
  assign out_tuser  = res_ovf_r;

endmodule

`default_nettype wire

// ----- design/complex_dot_product_conj_top.sv -----
// path: a last beat passes through the queue, the product stage register and the result register to out_tvalid
// throughput: one element pair per cycle through the single complex multiply-accumulate stage, while not held
// a result stalled on the output holds the back part only once the next last beat reaches it
// reset: synchronous active-low rst_n clears sums, overflow flag, conj bits and all valids
// ----------------------------------------------------------------------------
// complex_dot_product_conj_top
// streaming complex dot product with optional conjugation of either operand
// ----------------------------------------------------------------------------
`default_nettype none

module complex_dot_product_conj_top
  import cdp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = ACC_BITS_DEF,
  parameter int IN_DATA_W   = ((4 * SAMPLE_BITS + 7) / 8) * 8,
  parameter int OUT_DATA_W  = ((2 * ACC_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // register port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // x_real, x_imag, y_real, y_imag
  input  wire logic                  in_tuser,   // no_element
  input  wire logic                  in_tlast,
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // dot_real, dot_imag
  output logic                       out_tuser   // overflow
);

  localparam int ENTRY_W = 4 * SAMPLE_BITS + 2 + $bits(cdp_tag_t);

  logic               q_push, q_pop, q_full, q_not_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  // accept and conjugate
  cdp_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .IN_DATA_W   (IN_DATA_W),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .q_push      (q_push),
    .q_data      (q_wdata),
    .q_full      (q_full)
  );

  // decoupling queue
  cdp_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .not_empty (q_not_empty)
  );

  // multiply, accumulate, emit
  cdp_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS),
    .OUT_DATA_W  (OUT_DATA_W),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire
